// ===== rtl/core/rmq_pkg.sv =====
// Shared constants and types for the rotation matrix to quaternion core.
package rmq_pkg;

   localparam int FRAC_BITS = 14;
   localparam int DATA_W    = 16;
   localparam int TERM_W    = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
   localparam int RAD_W     = TERM_W - 1 + FRAC_BITS;
   localparam int ROOT_W    = (RAD_W + 1) / 2;
   localparam int QUO_W     = DATA_W;
   localparam int NUM_W     = RAD_W + 1;
   localparam int REM_W     = ((NUM_W > ROOT_W + QUO_W) ? NUM_W : ROOT_W + QUO_W) + 1;
   localparam int LANE_LAT  = QUO_W + 2;
   localparam int TOTAL_LAT = 1 + ROOT_W + LANE_LAT;

   typedef logic signed [TERM_W-1:0] term_type;
   typedef logic signed [DATA_W-1:0] data_type;
   typedef term_type term_vec_type [4];

endpackage

// ===== rtl/core/rmq_div_lane.sv =====
// Pipelined rounding divider with saturation for one quaternion component.
module rmq_div_lane (
   input  logic                              clock,
   input  logic                              adv,
   input  rmq_pkg::term_type                 term,
   input  logic [rmq_pkg::ROOT_W-1:0]        root,
   output rmq_pkg::data_type                 quat
);

   localparam int QW = rmq_pkg::QUO_W;
   localparam int RW = rmq_pkg::REM_W;

   logic [RW-1:0]                  rem_ff [0:QW];
   logic [QW-1:0]                  quo_ff [0:QW];
   logic [rmq_pkg::ROOT_W-1:0]     den_ff [0:QW];
   logic                           neg_ff [0:QW];
   logic                           ovf_ff [0:QW];
   rmq_pkg::data_type              quat_ff;

   logic                           neg_in;
   logic [rmq_pkg::TERM_W-1:0]     mag_in;
   logic [RW-1:0]                  num_in;
   logic [RW-1:0]                  lim_in;
   rmq_pkg::data_type              quat_in;

   always_comb begin
      neg_in = term[rmq_pkg::TERM_W-1];
      mag_in = neg_in ? (~term + 1'b1) : term;
      num_in = (RW'(mag_in) << (rmq_pkg::FRAC_BITS - 1)) + RW'(root >> 1);
      lim_in = RW'(root) << QW;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= num_in;
         quo_ff[0] <= '0;
         den_ff[0] <= root;
         neg_ff[0] <= neg_in;
         ovf_ff[0] <= (num_in >= lim_in);
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_step
      localparam int BIT = QW - 1 - k;
      logic [RW-1:0] sub_in;
      logic          ge_in;
      always_comb begin
         sub_in = RW'(den_ff[k]) << BIT;
         ge_in  = (rem_ff[k] >= sub_in);
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k+1] <= ge_in ? (rem_ff[k] - sub_in) : rem_ff[k];
            quo_ff[k+1] <= quo_ff[k] | (ge_in ? (QW'(1) << BIT) : '0);
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   always_comb begin
      if (neg_ff[QW]) begin
         if (ovf_ff[QW] || ({1'b0, quo_ff[QW]} > (QW + 1)'(32768))) begin
            quat_in = 16'sh8000;
         end else begin
            quat_in = rmq_pkg::data_type'(~quo_ff[QW] + 1'b1);
         end
      end else begin
         if (ovf_ff[QW] || ({1'b0, quo_ff[QW]} > (QW + 1)'(32767))) begin
            quat_in = 16'sh7fff;
         end else begin
            quat_in = rmq_pkg::data_type'(quo_ff[QW]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         quat_ff <= quat_in;
      end
   end

   assign quat = quat_ff;

endmodule

// ===== rtl/core/rotation_matrix_to_quaternion_core.sv =====
// Top level of the rotation matrix to quaternion core.
// Converts a 3x3 rotation matrix of signed Q1.14 entries into the quaternion
// (x, y, z, w) in signed Q1.14 with saturation. The core is a fully pipelined
// datapath that accepts one transaction per cycle while the output is not
// stalled. Its stages are one stage for case selection, one stage per root
// bit of the square root and one stage per quotient bit of the four dividers
// plus their setup and saturation stages.
// The whole pipeline holds while a finished result waits, so nothing is lost.
module rotation_matrix_to_quaternion_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rmq_pkg::data_type   req_c0r0,
   input  rmq_pkg::data_type   req_c0r1,
   input  rmq_pkg::data_type   req_c0r2,
   input  rmq_pkg::data_type   req_c1r0,
   input  rmq_pkg::data_type   req_c1r1,
   input  rmq_pkg::data_type   req_c1r2,
   input  rmq_pkg::data_type   req_c2r0,
   input  rmq_pkg::data_type   req_c2r1,
   input  rmq_pkg::data_type   req_c2r2,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rmq_pkg::data_type   rsp_quat_x,
   output rmq_pkg::data_type   rsp_quat_y,
   output rmq_pkg::data_type   rsp_quat_z,
   output rmq_pkg::data_type   rsp_quat_w
);

   localparam int TW  = rmq_pkg::TERM_W;
   localparam int NW  = rmq_pkg::RAD_W;
   localparam int QRW = rmq_pkg::ROOT_W;
   localparam int LAT = rmq_pkg::TOTAL_LAT;
   localparam rmq_pkg::term_type ONE = rmq_pkg::term_type'(1) << rmq_pkg::FRAC_BITS;

   logic                  adv;
   logic [LAT-1:0]        vld_ff;
   logic [NW:0]           rem_ff  [0:QRW];
   logic [QRW-1:0]        root_ff [0:QRW];
   rmq_pkg::term_vec_type term_ff [0:QRW];

   rmq_pkg::term_type     m0, m1, m2, m3, m4, m5, m6, m8, m7;
   rmq_pkg::term_type     t_in;
   rmq_pkg::term_type     tc_in;
   rmq_pkg::term_vec_type term_in;
   logic [NW:0]           rad_in;

   assign adv       = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   always_comb begin
      m0 = TW'(req_c0r0);
      m1 = TW'(req_c0r1);
      m2 = TW'(req_c0r2);
      m3 = TW'(req_c1r0);
      m4 = TW'(req_c1r1);
      m5 = TW'(req_c1r2);
      m6 = TW'(req_c2r0);
      m7 = TW'(req_c2r1);
      m8 = TW'(req_c2r2);
      if (m8 < 0) begin
         if (m0 > m4) begin
            t_in = ONE + m0 - m4 - m8;
            term_in[0] = t_in;    term_in[1] = m1 + m3;
            term_in[2] = m2 + m6; term_in[3] = m7 - m5;
         end else begin
            t_in = ONE - m0 + m4 - m8;
            term_in[0] = m1 + m3; term_in[1] = t_in;
            term_in[2] = m5 + m7; term_in[3] = m2 - m6;
         end
      end else begin
         if (m0 < -m4) begin
            t_in = ONE - m0 - m4 + m8;
            term_in[0] = m2 + m6; term_in[1] = m5 + m7;
            term_in[2] = t_in;    term_in[3] = m3 - m1;
         end else begin
            t_in = ONE + m0 + m4 + m8;
            term_in[0] = m7 - m5; term_in[1] = m2 - m6;
            term_in[2] = m3 - m1; term_in[3] = t_in;
         end
      end
      tc_in  = (t_in < 1) ? rmq_pkg::term_type'(1) : t_in;
      rad_in = {1'b0, tc_in[TW-2:0], {rmq_pkg::FRAC_BITS{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= rad_in;
         root_ff[0] <= '0;
         term_ff[0] <= term_in;
      end
   end

   for (genvar k = 0; k < QRW; k++) begin : g_sqrt
      localparam int BIT = QRW - 1 - k;
      logic [NW:0] trial_in;
      logic        ge_in;
      always_comb begin
         trial_in = ((NW + 1)'(root_ff[k]) << (BIT + 1)) + ((NW + 1)'(1) << (2 * BIT));
         ge_in    = (rem_ff[k] >= trial_in);
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k+1]  <= ge_in ? (rem_ff[k] - trial_in) : rem_ff[k];
            root_ff[k+1] <= root_ff[k] | (ge_in ? (QRW'(1) << BIT) : '0);
            term_ff[k+1] <= term_ff[k];
         end
      end
   end

   rmq_div_lane u_lane_x (
      .clock (clock), .adv (adv), .term (term_ff[QRW][0]), .root (root_ff[QRW]),
      .quat  (rsp_quat_x)
   );
   rmq_div_lane u_lane_y (
      .clock (clock), .adv (adv), .term (term_ff[QRW][1]), .root (root_ff[QRW]),
      .quat  (rsp_quat_y)
   );
   rmq_div_lane u_lane_z (
      .clock (clock), .adv (adv), .term (term_ff[QRW][2]), .root (root_ff[QRW]),
      .quat  (rsp_quat_z)
   );
   rmq_div_lane u_lane_w (
      .clock (clock), .adv (adv), .term (term_ff[QRW][3]), .root (root_ff[QRW]),
      .quat  (rsp_quat_w)
   );

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the rotation matrix to quaternion core.
`timescale 1ns / 1ps

module testbench;

   typedef struct {
      rmq_pkg::data_type m [9];
   } matrix_type;

   typedef struct {
      rmq_pkg::data_type x, y, z, w;
   } quat_type;

   localparam int RANDOM_ITEMS = 500;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   rmq_pkg::data_type req_m [9];
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rmq_pkg::data_type rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w;

   matrix_type pending_matrices [$];
   quat_type   expected_quats [$];
   int         failures = 0;
   bit         stimulus_done = 1'b0;
   bit         quiet_phase = 1'b0;
   int         hold_count = 0;
   int         send_gap = 0;
   int         recv_gap = 0;
   bit         long_hold_done = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rotation_matrix_to_quaternion_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_c0r0(req_m[0]), .req_c0r1(req_m[1]), .req_c0r2(req_m[2]),
      .req_c1r0(req_m[3]), .req_c1r1(req_m[4]), .req_c1r2(req_m[5]),
      .req_c2r0(req_m[6]), .req_c2r1(req_m[7]), .req_c2r2(req_m[8]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_quat_x(rsp_quat_x), .rsp_quat_y(rsp_quat_y),
      .rsp_quat_z(rsp_quat_z), .rsp_quat_w(rsp_quat_w)
   );

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned bitval;
      root = 0;
      bitval = 64'd1 << 62;
      while (bitval > n) bitval = bitval >> 2;
      while (bitval != 0) begin
         if (n >= root + bitval) begin
            n = n - (root + bitval);
            root = (root >> 1) + bitval;
         end else begin
            root = root >> 1;
         end
         bitval = bitval >> 2;
      end
      return root;
   endfunction

   function automatic rmq_pkg::data_type scaled_lane(longint term, longint unsigned root);
      longint unsigned mag;
      longint unsigned quo;
      mag = (term < 0) ? longint'(-term) : longint'(term);
      quo = ((mag << (rmq_pkg::FRAC_BITS - 1)) + root / 2) / root;
      if (term < 0) begin
         return (quo > 32768) ? rmq_pkg::data_type'(-32768)
                              : rmq_pkg::data_type'(-longint'(quo));
      end
      return (quo > 32767) ? rmq_pkg::data_type'(32767) : rmq_pkg::data_type'(quo);
   endfunction

   function automatic quat_type matrix_to_quat(matrix_type a);
      longint m [9];
      longint one, tr, qx, qy, qz, qw;
      longint unsigned root;
      quat_type q;
      one = longint'(1) << rmq_pkg::FRAC_BITS;
      for (int i = 0; i < 9; i++) m[i] = longint'(a.m[i]);
      if (m[8] < 0) begin
         if (m[0] > m[4]) begin
            tr = one + m[0] - m[4] - m[8];
            qx = tr; qy = m[1] + m[3]; qz = m[2] + m[6]; qw = m[7] - m[5];
         end else begin
            tr = one - m[0] + m[4] - m[8];
            qx = m[1] + m[3]; qy = tr; qz = m[5] + m[7]; qw = m[2] - m[6];
         end
      end else begin
         if (m[0] < -m[4]) begin
            tr = one - m[0] - m[4] + m[8];
            qx = m[2] + m[6]; qy = m[5] + m[7]; qz = tr; qw = m[3] - m[1];
         end else begin
            tr = one + m[0] + m[4] + m[8];
            qx = m[7] - m[5]; qy = m[2] - m[6]; qz = m[3] - m[1]; qw = tr;
         end
      end
      if (tr < 1) tr = 1;
      root = int_sqrt(longint'(tr) << rmq_pkg::FRAC_BITS);
      if (root == 0) root = 1;
      q.x = scaled_lane(qx, root);
      q.y = scaled_lane(qy, root);
      q.z = scaled_lane(qz, root);
      q.w = scaled_lane(qw, root);
      return q;
   endfunction

   function automatic rmq_pkg::data_type random_entry();
      case ($urandom_range(0, 9))
         0: return rmq_pkg::data_type'($urandom);
         1: return rmq_pkg::data_type'(16384);
         2: return rmq_pkg::data_type'(-16384);
         3: return rmq_pkg::data_type'($urandom_range(0, 8) - 4);
         default: return rmq_pkg::data_type'(int'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic matrix_type rotation_like(int axis, int c, int s);
      matrix_type a;
      rmq_pkg::data_type cv, sv, one;
      cv = rmq_pkg::data_type'(c);
      sv = rmq_pkg::data_type'(s);
      one = rmq_pkg::data_type'(16384);
      for (int i = 0; i < 9; i++) a.m[i] = '0;
      case (axis)
         0: begin
            a.m[0] = one; a.m[4] = cv; a.m[8] = cv; a.m[5] = sv; a.m[7] = -sv;
         end
         1: begin
            a.m[4] = one; a.m[0] = cv; a.m[8] = cv; a.m[2] = -sv; a.m[6] = sv;
         end
         default: begin
            a.m[8] = one; a.m[0] = cv; a.m[4] = cv; a.m[1] = sv; a.m[3] = -sv;
         end
      endcase
      return a;
   endfunction

   task automatic queue_matrix(input matrix_type a);
      pending_matrices.push_back(a);
   endtask

   initial begin
      matrix_type a;
      int c;
      queue_matrix(rotation_like(0, 16384, 0));
      queue_matrix(rotation_like(0, -16384, 0));
      queue_matrix(rotation_like(1, -16384, 0));
      queue_matrix(rotation_like(2, -16384, 0));
      queue_matrix(rotation_like(0, 0, 16384));
      queue_matrix(rotation_like(1, 0, -16384));
      queue_matrix(rotation_like(2, 11585, 11585));
      for (int v = 0; v < 4; v++) begin
         for (int i = 0; i < 9; i++)
            a.m[i] = (v == 0) ? rmq_pkg::data_type'(16'h8000) :
                     (v == 1) ? rmq_pkg::data_type'(16'h7fff) :
                     (v == 2) ? rmq_pkg::data_type'(-16384) : rmq_pkg::data_type'(16384);
         queue_matrix(a);
      end
      for (int i = 0; i < 9; i++) a.m[i] = '0;
      a.m[0] = rmq_pkg::data_type'(-16384);
      a.m[4] = rmq_pkg::data_type'(-16384);
      a.m[8] = rmq_pkg::data_type'(-16384);
      queue_matrix(a);
      a.m[8] = rmq_pkg::data_type'(16384);
      queue_matrix(a);
      for (int i = 0; i < 9; i++)
         a.m[i] = (i % 4 == 0) ? rmq_pkg::data_type'(-16384) : rmq_pkg::data_type'(0);
      a.m[8] = rmq_pkg::data_type'(16'h7fff);
      queue_matrix(a);
      for (int i = 0; i < 9; i++)
         a.m[i] = (i % 2 == 0) ? rmq_pkg::data_type'(16'h8000) : rmq_pkg::data_type'(16'h7fff);
      queue_matrix(a);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(0, 3) != 0) begin
            c = int'($urandom_range(0, 32768)) - 16384;
            a = rotation_like(int'($urandom_range(0, 2)), c,
                              int'($urandom_range(0, 32768)) - 16384);
            if ($urandom_range(0, 1)) a.m[$urandom_range(0, 8)] = random_entry();
         end else begin
            for (int i = 0; i < 9; i++) a.m[i] = random_entry();
         end
         queue_matrix(a);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         for (int i = 0; i < 9; i++) req_m[i] <= '0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) expected_quats.push_back(matrix_to_quat(matrix_type'{m: req_m}));
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_matrices.size() > 0) begin
            matrix_type a;
            a = pending_matrices.pop_front();
            req_m <= a.m;
            req_valid <= 1'b1;
            if (!quiet_phase && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 4);
            if (pending_matrices.size() < 60) quiet_phase <= 1'b1;
         end else begin
            req_valid <= 1'b0;
            stimulus_done <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_quats.size() == 0) begin
               $display("%0t: unexpected transaction x=%0d y=%0d z=%0d w=%0d",
                        $time, rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w);
               failures++;
            end else begin
               quat_type e;
               e = expected_quats.pop_front();
               if (rsp_quat_x !== e.x) begin
                  $display("%0t: quat_x expected %0d actual %0d", $time, e.x, rsp_quat_x);
                  failures++;
               end
               if (rsp_quat_y !== e.y) begin
                  $display("%0t: quat_y expected %0d actual %0d", $time, e.y, rsp_quat_y);
                  failures++;
               end
               if (rsp_quat_z !== e.z) begin
                  $display("%0t: quat_z expected %0d actual %0d", $time, e.z, rsp_quat_z);
                  failures++;
               end
               if (rsp_quat_w !== e.w) begin
                  $display("%0t: quat_w expected %0d actual %0d", $time, e.w, rsp_quat_w);
                  failures++;
               end
            end
         end
         if (hold_count > 0) begin
            hold_count <= hold_count - 1;
            rsp_ready <= 1'b0;
         end else if (!long_hold_done && expected_quats.size() > 20) begin
            long_hold_done <= 1'b1;
            hold_count <= 120;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet_phase && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 4);
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done && expected_quats.size() == 0);
      repeat (rmq_pkg::TOTAL_LAT + 10) @(posedge clock);
      if (failures == 0 && expected_quats.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
